// ----- src/i2c_master_transfer_sequencer_defines.svh -----
// Assertion macros for the I2C master transfer sequencer checker
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH

// check a property outside of reset
`define I2CS_CHECK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every edge, reset included
`define I2CS_CHECK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/i2cs_pkg.sv -----
// Shared types and constants for the I2C master transfer sequencer
package i2cs_pkg;

    localparam int CMD_DEPTH_DEF  = 16;
    localparam int DATA_DEPTH_DEF = 256;

    localparam int FLAG_SB   = 0;
    localparam int FLAG_ADDR = 1;
    localparam int FLAG_TXE  = 2;
    localparam int FLAG_BTF  = 3;
    localparam int FLAG_RXNE = 4;
    localparam int FLAG_NACK = 5;

    typedef enum logic [2:0] {
        OP_LOAD_CMD  = 3'd0,
        OP_LOAD_DATA = 3'd1,
        OP_START_WR  = 3'd2,
        OP_START_RD  = 3'd3,
        OP_EVENT     = 3'd4,
        OP_BUS_ERR   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        CTL_KEEP    = 2'd0,
        CTL_ENABLE  = 2'd1,
        CTL_DISABLE = 2'd2
    } t_ctl;

    typedef enum logic [1:0] {
        ERR_OK   = 2'd0,
        ERR_NACK = 2'd1,
        ERR_BUS  = 2'd2
    } t_err;

    typedef struct packed {
        logic [2:0] operation;
        logic [6:0] slave_address;
        logic [4:0] cmd_length;
        logic [7:0] transfer_length;
        logic [7:0] byte_index;
        logic [7:0] byte_in;
        logic [5:0] status_flags;
    } t_item;

    typedef struct packed {
        logic       drive_valid;
        logic [7:0] drive_byte;
        logic       request_start;
        logic       request_stop;
        t_ctl       ack_control;
        t_ctl       buffer_irq_control;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [7:0] rx_index;
        logic       done_res;
        t_err       error_code;
    } t_result;

endpackage

// ----- src/i2cs_store.sv -----
// Byte store with one write port and a registered, write-forwarding read port
module i2cs_store #(
    parameter int DEPTH = i2cs_pkg::CMD_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/i2cs_core.sv -----
// Transfer state, counters and per-request decision logic
module i2cs_core #(
    parameter int CMD_DEPTH  = i2cs_pkg::CMD_DEPTH_DEF,
    parameter int DATA_DEPTH = i2cs_pkg::DATA_DEPTH_DEF,
    parameter int CAW        = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1,
    parameter int DAW        = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  i2cs_pkg::t_item   i_item,
    input  logic [7:0]        i_cmd_rd_data,
    input  logic [7:0]        i_data_rd_data,
    output i2cs_pkg::t_result o_result,
    output logic              o_cmd_wr_en,
    output logic [CAW-1:0]    o_cmd_wr_addr,
    output logic [CAW-1:0]    o_cmd_rd_addr,
    output logic              o_data_wr_en,
    output logic [DAW-1:0]    o_data_wr_addr,
    output logic [7:0]        o_data_wr_data,
    output logic [DAW-1:0]    o_data_rd_addr
);

    localparam int CRW = $clog2(CMD_DEPTH + 1);
    localparam int DRW = $clog2(DATA_DEPTH + 1);

    logic           r_active, n_active;
    logic [6:0]     r_target, n_target;
    logic [CRW-1:0] r_cmd_rem, n_cmd_rem;
    logic [DRW-1:0] r_wr_rem, n_wr_rem;
    logic [DRW-1:0] r_rd_rem, n_rd_rem;
    logic [CAW-1:0] r_cmd_pos, n_cmd_pos;
    logic [DAW-1:0] r_data_pos, n_data_pos;

    logic [CAW-1:0] cmd_pos_inc;
    logic [DAW-1:0] data_pos_inc;
    logic [5:0]     flags;

    assign flags        = i_item.status_flags;
    assign cmd_pos_inc  = (r_cmd_pos == CAW'(CMD_DEPTH - 1)) ? '0 : r_cmd_pos + CAW'(1);
    assign data_pos_inc = (r_data_pos == DAW'(DATA_DEPTH - 1)) ? '0 : r_data_pos + DAW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_target   <= '0;
            r_cmd_rem  <= '0;
            r_wr_rem   <= '0;
            r_rd_rem   <= '0;
            r_cmd_pos  <= '0;
            r_data_pos <= '0;
        end else begin
            r_active   <= n_active;
            r_target   <= n_target;
            r_cmd_rem  <= n_cmd_rem;
            r_wr_rem   <= n_wr_rem;
            r_rd_rem   <= n_rd_rem;
            r_cmd_pos  <= n_cmd_pos;
            r_data_pos <= n_data_pos;
        end
    end

    always_comb begin
        n_active       = r_active;
        n_target       = r_target;
        n_cmd_rem      = r_cmd_rem;
        n_wr_rem       = r_wr_rem;
        n_rd_rem       = r_rd_rem;
        n_cmd_pos      = r_cmd_pos;
        n_data_pos     = r_data_pos;
        o_result       = '0;
        o_cmd_wr_en    = 1'b0;
        o_cmd_wr_addr  = i_item.byte_index[CAW-1:0];
        o_data_wr_en   = 1'b0;
        o_data_wr_addr = i_item.byte_index[DAW-1:0];
        o_data_wr_data = i_item.byte_in;
        if (i_go) begin
            unique case (i2cs_pkg::t_op'(i_item.operation))
                i2cs_pkg::OP_LOAD_CMD: begin
                    o_cmd_wr_en = (32'(i_item.byte_index) < CMD_DEPTH);
                end
                i2cs_pkg::OP_LOAD_DATA: begin
                    o_data_wr_en = (32'(i_item.byte_index) < DATA_DEPTH);
                end
                i2cs_pkg::OP_START_WR, i2cs_pkg::OP_START_RD: begin
                    n_active   = 1'b1;
                    n_target   = i_item.slave_address;
                    n_cmd_rem  = (32'(i_item.cmd_length) > CMD_DEPTH) ?
                                 CRW'(CMD_DEPTH) : CRW'(i_item.cmd_length);
                    n_wr_rem   = '0;
                    n_rd_rem   = '0;
                    if (i2cs_pkg::t_op'(i_item.operation) == i2cs_pkg::OP_START_WR) begin
                        n_wr_rem = (32'(i_item.transfer_length) > DATA_DEPTH) ?
                                   DRW'(DATA_DEPTH) : DRW'(i_item.transfer_length);
                    end else begin
                        n_rd_rem = (32'(i_item.transfer_length) > DATA_DEPTH) ?
                                   DRW'(DATA_DEPTH) : DRW'(i_item.transfer_length);
                    end
                    n_cmd_pos  = '0;
                    n_data_pos = '0;
                    o_result.request_start = 1'b1;
                    o_result.ack_control   = i2cs_pkg::CTL_DISABLE;
                end
                i2cs_pkg::OP_EVENT: begin
                    if (r_active) begin
                        priority if (flags[i2cs_pkg::FLAG_SB]) begin
                            o_result.drive_valid = 1'b1;
                            o_result.drive_byte  = {r_target,
                                                    (r_cmd_rem == '0) && (r_wr_rem == '0)};
                        end else if (flags[i2cs_pkg::FLAG_ADDR]) begin
                            n_cmd_pos  = '0;
                            n_data_pos = '0;
                            o_result.ack_control = (r_rd_rem > DRW'(1)) ?
                                                   i2cs_pkg::CTL_ENABLE : i2cs_pkg::CTL_KEEP;
                            o_result.buffer_irq_control = i2cs_pkg::CTL_ENABLE;
                        end else if (flags[i2cs_pkg::FLAG_TXE]) begin
                            priority if (r_cmd_rem != '0) begin
                                o_result.drive_valid = 1'b1;
                                o_result.drive_byte  = i_cmd_rd_data;
                                n_cmd_pos = cmd_pos_inc;
                                n_cmd_rem = r_cmd_rem - CRW'(1);
                                if (r_cmd_rem == CRW'(1)) begin
                                    n_data_pos = '0;
                                end
                            end else if (r_wr_rem != '0) begin
                                o_result.drive_valid = 1'b1;
                                o_result.drive_byte  = i_data_rd_data;
                                n_data_pos = data_pos_inc;
                                n_wr_rem   = r_wr_rem - DRW'(1);
                            end else if (r_rd_rem != '0) begin
                                if (flags[i2cs_pkg::FLAG_BTF]) begin
                                    o_result.request_start = 1'b1;
                                end else begin
                                    o_result.buffer_irq_control = i2cs_pkg::CTL_DISABLE;
                                end
                            end else begin
                                o_result.request_stop = 1'b1;
                                o_result.done_res     = 1'b1;
                                o_result.error_code   = i2cs_pkg::ERR_OK;
                                n_active              = 1'b0;
                            end
                        end else if (flags[i2cs_pkg::FLAG_RXNE]) begin
                            if (r_rd_rem != '0) begin
                                o_data_wr_en   = 1'b1;
                                o_data_wr_addr = r_data_pos;
                                o_result.rx_valid = 1'b1;
                                o_result.rx_byte  = i_item.byte_in;
                                o_result.rx_index = 8'(r_data_pos);
                                n_data_pos = data_pos_inc;
                                n_rd_rem   = r_rd_rem - DRW'(1);
                                if (r_rd_rem == DRW'(1)) begin
                                    o_result.done_res   = 1'b1;
                                    o_result.error_code = i2cs_pkg::ERR_OK;
                                    n_active            = 1'b0;
                                end else if (r_rd_rem == DRW'(2)) begin
                                    o_result.ack_control  = i2cs_pkg::CTL_DISABLE;
                                    o_result.request_stop = 1'b1;
                                end
                            end
                        end
                    end
                end
                i2cs_pkg::OP_BUS_ERR: begin
                    if (flags[i2cs_pkg::FLAG_NACK]) begin
                        o_result.request_stop = 1'b1;
                        if (r_active) begin
                            o_result.done_res   = 1'b1;
                            o_result.error_code = i2cs_pkg::ERR_NACK;
                        end
                    end else if (r_active) begin
                        o_result.done_res   = 1'b1;
                        o_result.error_code = i2cs_pkg::ERR_BUS;
                    end
                    n_active = 1'b0;
                end
                default: begin
                    n_active = r_active;
                end
            endcase
        end
    end

    assign o_cmd_rd_addr  = n_cmd_pos;
    assign o_data_rd_addr = n_data_pos;

endmodule

// ----- src/i2c_master_transfer_sequencer.sv -----
// Top level of the I2C master transfer sequencer
//
// Requests enter on the in channel (i_in_valid / o_in_stall) with the fields
// operation, slave_address, cmd_length, transfer_length, byte_index, byte_in
// and status_flags. Every request produces exactly one result on the out
// channel (o_out_valid / i_out_stall): drive byte, start/stop requests, ACK and
// buffer event control, received byte with index, done and error code.
// A request is registered at acceptance and evaluated, once the output register
// can take a result, against the transfer counters and the prefetched store
// words; the result lands in the output register. One request is accepted
// every cycle while o_in_stall is low. The command and data stores
// each have one write and one registered read port; their read address
// follows the next position so the word is ready when the request is evaluated.
// A stalled result holds in the output register; the input register keeps
// taking a request until it is full, then o_in_stall rises.
// Synchronous reset clears the transfer state and both valid flags; store
// contents are undefined until loaded.
module i2c_master_transfer_sequencer #(
    parameter int CMD_DEPTH  = i2cs_pkg::CMD_DEPTH_DEF,
    parameter int DATA_DEPTH = i2cs_pkg::DATA_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_operation,
    input  logic [6:0] i_slave_address,
    input  logic [4:0] i_cmd_length,
    input  logic [7:0] i_transfer_length,
    input  logic [7:0] i_byte_index,
    input  logic [7:0] i_byte_in,
    input  logic [5:0] i_status_flags,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_drive_valid,
    output logic [7:0] o_drive_byte,
    output logic       o_request_start,
    output logic       o_request_stop,
    output logic [1:0] o_ack_control,
    output logic [1:0] o_buffer_irq_control,
    output logic       o_rx_valid,
    output logic [7:0] o_rx_byte,
    output logic [7:0] o_rx_index,
    output logic       o_done_res,
    output logic [1:0] o_error_code
);

    localparam int CAW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int DAW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

    logic              r_in_valid;
    i2cs_pkg::t_item   r_item;
    logic              r_out_valid;
    i2cs_pkg::t_result r_result;

    i2cs_pkg::t_result core_result;
    logic              advance;
    logic              go;
    logic              cmd_wr_en;
    logic [CAW-1:0]    cmd_wr_addr;
    logic [CAW-1:0]    cmd_rd_addr;
    logic [7:0]        cmd_rd_data;
    logic              data_wr_en;
    logic [DAW-1:0]    data_wr_addr;
    logic [7:0]        data_wr_data;
    logic [DAW-1:0]    data_rd_addr;
    logic [7:0]        data_rd_data;

    assign advance    = !r_out_valid || !i_out_stall;
    assign go         = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item <= '{operation:       i_operation,
                        slave_address:   i_slave_address,
                        cmd_length:      i_cmd_length,
                        transfer_length: i_transfer_length,
                        byte_index:      i_byte_index,
                        byte_in:         i_byte_in,
                        status_flags:    i_status_flags};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_result <= core_result;
        end
    end

    i2cs_core #(
        .CMD_DEPTH  (CMD_DEPTH),
        .DATA_DEPTH (DATA_DEPTH),
        .CAW        (CAW),
        .DAW        (DAW)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (go),
        .i_item         (r_item),
        .i_cmd_rd_data  (cmd_rd_data),
        .i_data_rd_data (data_rd_data),
        .o_result       (core_result),
        .o_cmd_wr_en    (cmd_wr_en),
        .o_cmd_wr_addr  (cmd_wr_addr),
        .o_cmd_rd_addr  (cmd_rd_addr),
        .o_data_wr_en   (data_wr_en),
        .o_data_wr_addr (data_wr_addr),
        .o_data_wr_data (data_wr_data),
        .o_data_rd_addr (data_rd_addr)
    );

    i2cs_store #(
        .DEPTH (CMD_DEPTH),
        .AW    (CAW)
    ) u_cmd_store (
        .i_clk     (i_clk),
        .i_wr_en   (cmd_wr_en),
        .i_wr_addr (cmd_wr_addr),
        .i_wr_data (r_item.byte_in),
        .i_rd_addr (cmd_rd_addr),
        .o_rd_data (cmd_rd_data)
    );

    i2cs_store #(
        .DEPTH (DATA_DEPTH),
        .AW    (DAW)
    ) u_data_store (
        .i_clk     (i_clk),
        .i_wr_en   (data_wr_en),
        .i_wr_addr (data_wr_addr),
        .i_wr_data (data_wr_data),
        .i_rd_addr (data_rd_addr),
        .o_rd_data (data_rd_data)
    );

    assign o_out_valid          = r_out_valid;
    assign o_drive_valid        = r_result.drive_valid;
    assign o_drive_byte         = r_result.drive_byte;
    assign o_request_start      = r_result.request_start;
    assign o_request_stop       = r_result.request_stop;
    assign o_ack_control        = r_result.ack_control;
    assign o_buffer_irq_control = r_result.buffer_irq_control;
    assign o_rx_valid           = r_result.rx_valid;
    assign o_rx_byte            = r_result.rx_byte;
    assign o_rx_index           = r_result.rx_index;
    assign o_done_res           = r_result.done_res;
    assign o_error_code         = r_result.error_code;

endmodule

// ----- src/i2cs_checker.sv -----
// Port-level checker for the I2C master transfer sequencer, with its bind
`include "i2c_master_transfer_sequencer_defines.svh"

module i2cs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_drive_valid,
    input logic       o_request_start,
    input logic       o_rx_valid,
    input logic       o_done_res,
    input logic [1:0] o_error_code
);

    `I2CS_CHECK_ALWAYS(a_reset_clears_out, i_clk,
        !i_rst_n |=> !o_out_valid, "result valid after reset")

    `I2CS_CHECK(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> o_out_valid, "stalled result dropped")

    `I2CS_CHECK(a_err_needs_done, i_clk, i_rst_n,
        o_out_valid && (o_error_code != i2cs_pkg::ERR_OK) |-> o_done_res,
        "error code without done")

    `I2CS_CHECK(a_rx_not_drive, i_clk, i_rst_n,
        o_out_valid && o_rx_valid |-> !o_drive_valid && !o_request_start,
        "receive result also drives the bus")

    `I2CS_CHECK(a_done_not_drive, i_clk, i_rst_n,
        o_out_valid && o_done_res |-> !o_drive_valid && !o_request_start,
        "done result also drives the bus")

endmodule

bind i2c_master_transfer_sequencer i2cs_checker u_checker (.*);
